>>> rtl/json_nesting_prescan_macros.svh
// ----------------------------------------------------------------------------
// json_nesting_prescan assertion macros
// Shared concurrent assertion forms for the prescan RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_NESTING_PRESCAN_MACROS_SVH
`define JSON_NESTING_PRESCAN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JNP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jnp assertion failed");

// Next-cycle implication, disabled during reset.
`define JNP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jnp assertion failed");

`endif

>>> rtl/jnp_pkg.sv
// ----------------------------------------------------------------------------
// jnp_pkg
// Types, codes and constants shared by the JSON nesting prescan RTL.
// ----------------------------------------------------------------------------
package jnp_pkg;

  localparam int DEPTH_W    = 4;
  localparam int LEN_W      = 17;
  localparam int STAGE_W    = 3;
  localparam int REASON_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd1;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST  = 4'd8;
  localparam logic [LEN_W-1:0]   MAX_LENGTH_RST = 17'd8192;
  localparam logic [LEN_W-1:0]   COUNT_MAX      = 17'h1FFFF;

  // reject reasons
  localparam logic [REASON_W-1:0] RSN_NONE      = 3'd0;
  localparam logic [REASON_W-1:0] RSN_NUL       = 3'd1;
  localparam logic [REASON_W-1:0] RSN_TOO_DEEP  = 3'd2;
  localparam logic [REASON_W-1:0] RSN_STRAY     = 3'd3;
  localparam logic [REASON_W-1:0] RSN_ESC_NUL   = 3'd4;
  localparam logic [REASON_W-1:0] RSN_TRAIL_BS  = 3'd5;
  localparam logic [REASON_W-1:0] RSN_UNCLOSED  = 3'd6;
  localparam logic [REASON_W-1:0] RSN_TOO_LONG  = 3'd7;

  // \u0000 tracker: idle, after "\u", then one more per zero digit
  localparam logic [STAGE_W-1:0] ESC_IDLE    = 3'd0;
  localparam logic [STAGE_W-1:0] ESC_AFTER_U = 3'd1;
  localparam logic [STAGE_W-1:0] ESC_DONE    = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic                inside_string;
    logic                escape_pending;
    logic [STAGE_W-1:0]  nul_escape_stage;
    logic [DEPTH_W-1:0]  nesting_depth;
    logic [LEN_W-1:0]    byte_count;
    logic [REASON_W-1:0] first_error;
  } jnp_state_t;

  typedef struct packed {
    logic                accepted;
    logic [REASON_W-1:0] reject_reason;
  } jnp_verdict_t;

endpackage

>>> rtl/jnp_in_if.sv
// ----------------------------------------------------------------------------
// jnp_in_if
// Byte input channel: one message byte plus end-of-message flag.
// ----------------------------------------------------------------------------
interface jnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

>>> rtl/jnp_out_if.sv
// ----------------------------------------------------------------------------
// jnp_out_if
// Verdict output channel: pass flag and first reject reason.
// ----------------------------------------------------------------------------
interface jnp_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] reject_reason;

  modport source (output valid, output accepted, output reject_reason, input ready);
  modport sink   (input valid, input accepted, input reject_reason, output ready);
endinterface

>>> rtl/jnp_scan.sv
// ----------------------------------------------------------------------------
// jnp_scan
// Per-byte next-state and verdict logic of the JSON structure prescan.
// ----------------------------------------------------------------------------
module jnp_scan
  import jnp_pkg::*;
(
  input  jnp_state_t          cur,
  input  logic [7:0]          text_byte,
  input  logic                is_last,
  input  logic [DEPTH_W-1:0]  max_depth,
  input  logic [LEN_W-1:0]    max_length,
  output jnp_state_t          state_next,
  output jnp_verdict_t        verdict
);

  jnp_state_t          upd;
  logic                in_str;
  logic                is_open;
  logic                is_close;
  logic [REASON_W-1:0] reason;

  assign is_open  = (text_byte == CH_LBRACE) || (text_byte == CH_LBRACK);
  assign is_close = (text_byte == CH_RBRACE) || (text_byte == CH_RBRACK);

  always_comb begin
    upd    = cur;
    in_str = cur.inside_string;
    if (cur.byte_count != COUNT_MAX) begin
      upd.byte_count = cur.byte_count + LEN_W'(1);
    end
    // once an error is latched the scan freezes; only the count moves
    if (cur.first_error == RSN_NONE) begin
      if (text_byte == CH_NUL) begin
        upd.first_error = RSN_NUL;
      end else if (cur.escape_pending) begin
        upd.escape_pending   = 1'b0;
        upd.nul_escape_stage = (text_byte == CH_U) ? ESC_AFTER_U : ESC_IDLE;
      end else if (cur.nul_escape_stage != ESC_IDLE && text_byte == CH_ZERO) begin
        if (cur.nul_escape_stage == ESC_DONE) begin
          upd.first_error      = RSN_ESC_NUL;
          upd.nul_escape_stage = ESC_IDLE;
        end else begin
          upd.nul_escape_stage = cur.nul_escape_stage + STAGE_W'(1);
        end
      end else begin
        upd.nul_escape_stage = ESC_IDLE;
        if (cur.inside_string && text_byte == CH_BSLASH) begin
          upd.escape_pending = 1'b1;
        end else begin
          in_str            = cur.inside_string ^ (text_byte == CH_QUOTE);
          upd.inside_string = in_str;
          if (!in_str) begin
            if (is_open) begin
              if (({1'b0, cur.nesting_depth} + 5'd1) > {1'b0, max_depth}) begin
                upd.first_error = RSN_TOO_DEEP;
              end else begin
                upd.nesting_depth = cur.nesting_depth + DEPTH_W'(1);
              end
            end else if (is_close) begin
              if (cur.nesting_depth == '0) begin
                upd.first_error = RSN_STRAY;
              end else begin
                upd.nesting_depth = cur.nesting_depth - DEPTH_W'(1);
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    reason = upd.first_error;
    if (reason == RSN_NONE) begin
      if (upd.escape_pending) begin
        reason = RSN_TRAIL_BS;
      end else if (upd.inside_string || upd.nesting_depth != '0) begin
        reason = RSN_UNCLOSED;
      end
    end
    // length overrides everything else
    if (upd.byte_count > max_length) begin
      reason = RSN_TOO_LONG;
    end
  end

  assign verdict.reject_reason = reason;
  assign verdict.accepted      = (reason == RSN_NONE);
  assign state_next            = is_last ? '0 : upd;

endmodule

>>> rtl/json_nesting_prescan.sv
// ----------------------------------------------------------------------------
// json_nesting_prescan
// Streaming structural pre-check of JSON messages, one byte per transaction.
// ----------------------------------------------------------------------------
//   channel   dir   payload                          transaction
//   in_ch     in    text_byte[7:0], is_last          one message byte
//   out_ch    out   accepted, reject_reason[2:0]     one verdict per message
//   cfg_*     in    cfg_index[0], cfg_data[16:0]     register write
//
// One byte per cycle unless in_ch is stalled; the scan state register is the only loop.
// The verdict appears in the output register the cycle after the last byte.
// in_ch stalls only while a verdict waits in the output register and
// out_ch.ready is low. Reset clears message state and loads register defaults.
// ----------------------------------------------------------------------------
`include "json_nesting_prescan_macros.svh"

module json_nesting_prescan
  import jnp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  jnp_in_if.sink                in_ch,
  jnp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  jnp_state_t          st;
  jnp_state_t          st_next;
  jnp_verdict_t        verdict;
  logic [DEPTH_W-1:0]  max_depth;
  logic [LEN_W-1:0]    max_length;
  logic                out_vld;
  logic                out_accepted;
  logic [REASON_W-1:0] out_reason;
  logic                in_fire;

  assign in_ch.ready = !out_vld || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  jnp_scan u_scan (
    .cur        (st),
    .text_byte  (in_ch.text_byte),
    .is_last    (in_ch.is_last),
    .max_depth  (max_depth),
    .max_length (max_length),
    .state_next (st_next),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth  <= MAX_DEPTH_RST;
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_DEPTH:  max_depth  <= cfg_data[DEPTH_W-1:0];
        CFG_MAX_LENGTH: max_length <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '0;
      out_vld <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= st_next;
      end
      if (in_fire && in_ch.is_last) begin
        out_vld <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.is_last) begin
      out_accepted <= verdict.accepted;
      out_reason   <= verdict.reject_reason;
    end
  end

  assign out_ch.valid         = out_vld;
  assign out_ch.accepted      = out_accepted;
  assign out_ch.reject_reason = out_reason;

  `JNP_ASSERT_NEXT(a_last_gives_verdict, clk, rst, in_fire && in_ch.is_last, out_vld)
  `JNP_ASSERT_NEXT(a_last_clears_state, clk, rst, in_fire && in_ch.is_last,
                   st.byte_count == '0 && st.first_error == RSN_NONE)
  `JNP_ASSERT_SAME(a_verdict_consistent, clk, rst, out_vld,
                   out_accepted == (out_reason == RSN_NONE))
  `JNP_ASSERT_SAME(a_escape_in_string, clk, rst, st.escape_pending, st.inside_string)
  `JNP_ASSERT_SAME(a_stage_range, clk, rst, 1'b1, st.nul_escape_stage <= ESC_DONE)

endmodule
